### hw/rtl/l2acl_pkg.sv
// Shared constants, codes and types of the port-range rule table.
package l2acl_pkg;

  localparam int RULE_SLOTS = 64;
  localparam int SLOT_W     = $clog2(RULE_SLOTS);
  localparam int CNT_W      = $clog2(RULE_SLOTS + 1);
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam int CMD_W  = 3;
  localparam int ID_W   = 6;
  localparam int PORT_W = 16;
  localparam int RANK_W = 17;
  localparam int LIVE_W = 7;
  localparam int STAT_W = 2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  // Bit positions of the result word fields.
  localparam int OUT_ID_LSB   = 0;
  localparam int OUT_RANK_LSB = OUT_ID_LSB + ID_W;
  localparam int OUT_LIVE_LSB = OUT_RANK_LSB + RANK_W;
  localparam int OUT_TOP_LSB  = OUT_LIVE_LSB + LIVE_W;
  localparam int OUT_CHG_BIT  = OUT_TOP_LSB + ID_W;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_MATCH  = 2'd3;

  localparam logic signed [RANK_W-1:0] RANK_NONE = -17'sd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              tgt_ok;
    logic [ID_W-1:0]   tgt;
    logic [PORT_W-1:0] lo;
    logic [PORT_W-1:0] hi;
    logic [PORT_W-1:0] rank;
    logic [PORT_W-1:0] port;
  } acl_req_t;

  typedef struct packed {
    logic [PORT_W-1:0] lo;
    logic [PORT_W-1:0] hi;
    logic [PORT_W-1:0] rank;
  } acl_rule_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [ID_W-1:0]          id;
    logic signed [RANK_W-1:0] rank;
    logic [LIVE_W-1:0]        live;
    logic [ID_W-1:0]          top;
    logic                     changed;
  } acl_rsp_t;

endpackage

### hw/rtl/l2_port_range_acl_table_unit.sv
// Top level of the port-range rule table with priority lookup.
//
//   Channel  Direction  tdata fields (low bit up)                     tuser
//   in_      slave      target_id, range_low, range_high, rule_rank,  command
//                       probe_port, zero fill to 72 bits
//   out_     master     result_id, result_rank, live_count, top_id,   status
//                       changed, zero fill to 40 bits
//
// Work per word: add walks the slots upward from slot 0 to the lowest free one
// (through all RULE_SLOTS slots when the table is full); lookup and query scan
// every slot through the one read port of the rule memory, a slot a cycle; a
// delete that hits steps the top index down over freed slots; update, unknown
// commands and a delete that misses its target go straight to the result.
// Reset clears the used bits, count, top index and dirty mark;
// the rule memory itself needs no clearing pass.
// A two-word queue parts the input stage from the engine, so words are taken
// while the engine scans or a result waits on out_tready, until the queue fills.
module l2_port_range_acl_table_unit import l2acl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: target_id[5:0], range_low[21:6], range_high[37:22],
  //        rule_rank[53:38], probe_port[69:54], zero[71:70]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: command[2:0]
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: result_id[5:0], result_rank[22:6], live_count[29:23],
  //        top_id[35:30], changed[36], zero[39:37]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser: status[1:0]
  output logic [STAT_W-1:0]      out_tuser
);

  acl_req_t front_req;
  logic     front_vld;
  logic     front_rdy;
  acl_req_t q_req;
  logic     q_vld;
  logic     q_rdy;
  acl_rsp_t rsp;

  // The input stage registers each word and flags targets beyond the table.
  l2acl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .req_vld   (front_vld),
    .req_rdy   (front_rdy),
    .req       (front_req)
  );

  // Commands wait here while the engine is busy with an earlier command.
  l2acl_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (front_vld),
    .push_rdy  (front_rdy),
    .push_data (front_req),
    .pop_vld   (q_vld),
    .pop_rdy   (q_rdy),
    .pop_data  (q_req)
  );

  // The engine owns the table state and drives the output register.
  l2acl_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (q_vld),
    .req_rdy (q_rdy),
    .req     (q_req),
    .rsp_vld (out_tvalid),
    .rsp_rdy (out_tready),
    .rsp     (rsp)
  );

  // Pack the result word; the status code travels as tuser.
  assign out_tuser = rsp.status;
  assign out_tdata = {3'b000, rsp.changed, rsp.top, rsp.live, rsp.rank, rsp.id};

endmodule

### hw/rtl/l2acl_front.sv
// Input stage: takes command words, unpacks them and checks the target range.
module l2acl_front import l2acl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  req_vld,
  input  logic                  req_rdy,
  output acl_req_t              req
);

  logic     hold_vld_r;
  acl_req_t hold_r;
  acl_req_t dec;

  always_comb begin
    dec.cmd    = in_tuser;
    dec.tgt    = in_tdata[5:0];
    dec.lo     = in_tdata[21:6];
    dec.hi     = in_tdata[37:22];
    dec.rank   = in_tdata[53:38];
    dec.port   = in_tdata[69:54];
    dec.tgt_ok = (32'(in_tdata[5:0]) < 32'(RULE_SLOTS));
  end

  assign in_tready = !hold_vld_r || req_rdy;
  assign req_vld   = hold_vld_r;
  assign req       = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_tready) begin
      hold_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r <= dec;
    end
  end

endmodule

### hw/rtl/l2acl_fifo.sv
// Short command queue between the input stage and the table engine.
module l2acl_fifo import l2acl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_vld,
  output logic     push_rdy,
  input  acl_req_t push_data,
  output logic     pop_vld,
  input  logic     pop_rdy,
  output acl_req_t pop_data
);

  acl_req_t          q_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_rdy = (cnt_r != QCNT_W'(Q_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign pop_data = q_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/l2acl_engine.sv
// Table engine: rule memory, slot scans, bookkeeping and the result register.
module l2acl_engine import l2acl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_vld,
  output logic     req_rdy,
  input  acl_req_t req,
  output logic     rsp_vld,
  input  logic     rsp_rdy,
  output acl_rsp_t rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_TOP  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]               state_r, state_nxt;
  acl_req_t                 cur_r, cur_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [RULE_SLOTS-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]         total_r, total_nxt;
  logic [SLOT_W-1:0]        top_r, top_nxt;
  logic                     dirty_r, dirty_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic [SLOT_W-1:0]        rid_r, rid_nxt;
  logic signed [RANK_W-1:0] best_r, best_nxt;
  logic                     pipe_vld_r, pipe_vld_nxt;
  logic [SLOT_W-1:0]        pipe_idx_r, pipe_idx_nxt;
  logic                     out_vld_r, out_vld_nxt;
  acl_rsp_t                 out_r, out_nxt;

  acl_rule_t                mem [RULE_SLOTS];
  acl_rule_t                rd_data_r;
  logic                     mem_we;
  logic [SLOT_W-1:0]        mem_wa;
  acl_rule_t                mem_wd;
  logic                     rd_en;
  logic [SLOT_W-1:0]        rd_addr;

  logic [SLOT_W-1:0]        tidx;
  logic [SLOT_W-1:0]        cidx;
  logic                     scan_end;
  logic signed [RANK_W-1:0] rd_rank;
  logic                     in_range;
  logic                     hit;

  assign tidx     = SLOT_W'(req.tgt);
  assign cidx     = cnt_r[SLOT_W-1:0];
  assign scan_end = (cnt_r == CNT_W'(RULE_SLOTS));
  assign rd_rank  = {1'b0, rd_data_r.rank};
  assign in_range = (rd_data_r.lo <= cur_r.port) && (rd_data_r.hi >= cur_r.port);
  assign hit      = used_r[pipe_idx_r] && (rd_rank > best_r) &&
                    ((cur_r.cmd == CMD_QUERY) || in_range);

  assign rsp_vld = out_vld_r;
  assign rsp     = out_r;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    cnt_nxt      = cnt_r;
    used_nxt     = used_r;
    total_nxt    = total_r;
    top_nxt      = top_r;
    dirty_nxt    = dirty_r;
    status_nxt   = status_r;
    rid_nxt      = rid_r;
    best_nxt     = best_r;
    pipe_vld_nxt = 1'b0;
    pipe_idx_nxt = pipe_idx_r;
    out_vld_nxt  = out_vld_r && !rsp_rdy;
    out_nxt      = out_r;
    req_rdy      = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = cidx;
    mem_wd       = '{lo: cur_r.lo, hi: cur_r.hi, rank: cur_r.rank};
    rd_en        = 1'b0;
    rd_addr      = cidx;

    case (state_r)
      S_IDLE: begin
        if (req_vld) begin
          req_rdy    = 1'b1;
          cur_nxt    = req;
          cnt_nxt    = '0;
          status_nxt = ST_OK;
          rid_nxt    = '0;
          best_nxt   = RANK_NONE;
          case (req.cmd)
            CMD_ADD: begin
              state_nxt = S_ADD;
            end
            CMD_DELETE: begin
              if (req.tgt_ok && used_r[tidx]) begin
                used_nxt[tidx] = 1'b0;
                if (total_r != '0) begin
                  total_nxt = total_r - CNT_W'(1);
                end
                dirty_nxt = 1'b1;
                state_nxt = S_TOP;
              end else begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_DONE;
              end
            end
            CMD_UPDATE: begin
              if (req.tgt_ok && used_r[tidx]) begin
                mem_we    = 1'b1;
                mem_wa    = tidx;
                mem_wd    = '{lo: req.lo, hi: req.hi, rank: req.rank};
                dirty_nxt = 1'b1;
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
              state_nxt = S_DONE;
            end
            CMD_LOOKUP, CMD_QUERY: begin
              state_nxt = S_SCAN;
            end
            default: begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_ADD: begin
        if (scan_end) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else if (!used_r[cidx]) begin
          used_nxt[cidx] = 1'b1;
          mem_we         = 1'b1;
          total_nxt      = total_r + CNT_W'(1);
          if (cidx > top_r) begin
            top_nxt = cidx;
          end
          dirty_nxt = 1'b1;
          rid_nxt   = cidx;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_TOP: begin
        // Walk the top slot down past freed slots, one slot a cycle.
        if ((top_r != '0) && !used_r[top_r]) begin
          top_nxt = top_r - SLOT_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        if (!scan_end) begin
          rd_en        = 1'b1;
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = cidx;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end
        if (pipe_vld_r && hit) begin
          best_nxt = rd_rank;
          if (cur_r.cmd == CMD_LOOKUP) begin
            rid_nxt = pipe_idx_r;
          end
        end
        if (scan_end && !pipe_vld_r) begin
          if ((cur_r.cmd == CMD_LOOKUP) && best_r[RANK_W-1]) begin
            status_nxt = ST_NO_MATCH;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_r || rsp_rdy) begin
          out_vld_nxt     = 1'b1;
          out_nxt.status  = status_r;
          out_nxt.id      = ID_W'(rid_r);
          out_nxt.rank    = best_r;
          out_nxt.live    = LIVE_W'(total_r);
          out_nxt.top     = ID_W'(top_r);
          out_nxt.changed = dirty_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      used_r     <= '0;
      total_r    <= '0;
      top_r      <= '0;
      dirty_r    <= 1'b0;
      pipe_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      total_r    <= total_nxt;
      top_r      <= top_nxt;
      dirty_r    <= dirty_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    rid_r      <= rid_nxt;
    best_r     <= best_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/l2acl_chk.sv
// Port-level checks on the rule table result channel, bound to the top level.
module l2acl_chk import l2acl_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser
);

  localparam int LIVE_MAX = (RULE_SLOTS > 127) ? 127 : RULE_SLOTS;

  logic [ID_W-1:0]   res_id;
  logic [RANK_W-1:0] res_rank;
  logic [LIVE_W-1:0] res_live;

  assign res_id   = out_tdata[OUT_ID_LSB +: ID_W];
  assign res_rank = out_tdata[OUT_RANK_LSB +: RANK_W];
  assign res_live = out_tdata[OUT_LIVE_LSB +: LIVE_W];

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(res_live) <= LIVE_MAX))
    else $error("live count above table size");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |->
      (res_live == LIVE_W'(RULE_SLOTS)) && (res_id == '0))
    else $error("table reported full with free slots");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NO_MATCH) |->
      (res_rank == {RANK_W{1'b1}}) && (res_id == '0))
    else $error("no-match result carries a rule");

endmodule

bind l2_port_range_acl_table_unit l2acl_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
